// ===== src/cgbg_pkg.sv =====
// Shared types, codes and constants of the cost grid bilinear/gradient block.
// No dependencies; used by the controller, the datapath and the top level.
package cgbg_pkg;

    // Default sizes handed to the top level's parameters
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 8;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 16;
    localparam int VAL_W   = 8;
    localparam int COORD_W = 18;
    localparam int DIM_W   = 9;
    localparam int COST_W  = 24;
    localparam int GRAD_W  = 11;
    localparam int CADDR_W = 2 * DIM_W;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_MERGE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] GRID_DIM_RST = 9'd256;

    // Cost reported for a coordinate off the map, and cell read off the grid
    localparam logic [COST_W-1:0] OFF_COST = 24'hFF0000;
    localparam logic [VAL_W-1:0]  OFF_CELL = 8'hFF;

    // Query sequence: four interpolation reads, then eight gradient reads
    localparam int STEP_W     = 4;
    localparam logic [STEP_W-1:0] LAST_STEP  = 4'd11;
    localparam logic [STEP_W-1:0] DRAIN_LAST = 4'd1;

    localparam logic [1:0] KIND_INTERP = 2'd0;
    localparam logic [1:0] KIND_GX     = 2'd1;
    localparam logic [1:0] KIND_GY     = 2'd2;

    typedef struct packed {
        logic              trunc_base; // use truncated cell, else floor cell
        logic signed [2:0] dx;
        logic signed [2:0] dy;
        logic [1:0]        kind;
        logic              fx_sel;     // weight takes fx, else 1-fx
        logic              fy_sel;
        logic              neg;        // gradient term subtracts
        logic              dbl;        // gradient term counts twice
    } t_step;

    typedef struct packed {
        logic              latch;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              item_port;
        logic              mem_check;
        logic              load_wr;
        logic              merge_wr;
        logic              emit;
    } t_ctl_cmd;

    function automatic t_step step_info(input logic [STEP_W-1:0] s);
        t_step r;
        r = '0;
        unique case (s)
            4'd0: begin r.kind = KIND_INTERP; end
            4'd1: begin r.kind = KIND_INTERP; r.dx = 3'sd1; r.fx_sel = 1'b1; end
            4'd2: begin r.kind = KIND_INTERP; r.dy = 3'sd1; r.fy_sel = 1'b1; end
            4'd3: begin
                r.kind = KIND_INTERP; r.dx = 3'sd1; r.dy = 3'sd1;
                r.fx_sel = 1'b1; r.fy_sel = 1'b1;
            end
            4'd4:  begin r.trunc_base = 1'b1; r.kind = KIND_GX; r.dx = 3'sd1;  r.dbl = 1'b1; end
            4'd5:  begin
                r.trunc_base = 1'b1; r.kind = KIND_GX; r.dx = -3'sd1;
                r.dbl = 1'b1; r.neg = 1'b1;
            end
            4'd6:  begin r.trunc_base = 1'b1; r.kind = KIND_GX; r.dx = 3'sd2; end
            4'd7:  begin r.trunc_base = 1'b1; r.kind = KIND_GX; r.dx = -3'sd2; r.neg = 1'b1; end
            4'd8:  begin r.trunc_base = 1'b1; r.kind = KIND_GY; r.dy = 3'sd1;  r.dbl = 1'b1; end
            4'd9:  begin
                r.trunc_base = 1'b1; r.kind = KIND_GY; r.dy = -3'sd1;
                r.dbl = 1'b1; r.neg = 1'b1;
            end
            4'd10: begin r.trunc_base = 1'b1; r.kind = KIND_GY; r.dy = 3'sd2; end
            4'd11: begin r.trunc_base = 1'b1; r.kind = KIND_GY; r.dy = -3'sd2; r.neg = 1'b1; end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/cost_grid_bilinear_gradient.sv =====
// Top level of the cost grid with bilinear lookup and gradient.
// Depends on cgbg_pkg, cgbg_ctrl and cgbg_dpath.
//
// Usage:
//   Input channel: drive i_op and the item fields, raise i_start. A beat is
//   taken at a rising edge with i_start high and o_busy low.
//   Ops: load writes one cost byte, merge keeps the larger of old and new,
//   query samples the grid at a signed fixed-point coordinate.
//   Result channel: a query's result sits on the o_ ports for one cycle,
//   marked by o_valid. The receiver cannot stall it; capture it then.
//   Configuration: i_cfg_we writes i_cfg_data into grid width (index 0) or
//   grid height (index 1); write only while the block is idle.
//   Sequence: a load is one write, a merge a read, then a write back. A
//   query issues its twelve cell reads (four for the interpolation, eight
//   for the gradient) through the single grid memory port, one per cycle,
//   then drains the two-stage read pipeline; o_busy falls in the o_valid
//   cycle, so a new item is taken only after the last query's result.
//   Reset: clears the sequencer and the result strobe, sets both grid sizes
//   to 256. The grid memory is not cleared; load cells before reading them.
module cost_grid_bilinear_gradient #(
    parameter int MAX_WIDTH  = cgbg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cgbg_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = cgbg_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [cgbg_pkg::OP_W-1:0]           i_op,
    input  logic [cgbg_pkg::IDX_W-1:0]          i_cell_index,
    input  logic [cgbg_pkg::VAL_W-1:0]          i_cell_value,
    input  logic signed [cgbg_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [cgbg_pkg::COORD_W-1:0] i_query_y,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [cgbg_pkg::DIM_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic [cgbg_pkg::COST_W-1:0]         o_interp_cost,
    output logic signed [cgbg_pkg::GRAD_W-1:0]  o_grad_x,
    output logic signed [cgbg_pkg::GRAD_W-1:0]  o_grad_y,
    output logic                                o_inside_map
);
    cgbg_pkg::t_ctl_cmd cmd;

    // Sequencer: one item at a time, steps the query reads
    cgbg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_op),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    // Grid storage, address pipeline and accumulators
    cgbg_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cell_index  (i_cell_index),
        .i_cell_value  (i_cell_value),
        .i_query_x     (i_query_x),
        .i_query_y     (i_query_y),
        .o_valid       (o_valid),
        .o_interp_cost (o_interp_cost),
        .o_grad_x      (o_grad_x),
        .o_grad_y      (o_grad_y),
        .o_inside_map  (o_inside_map)
    );

endmodule

// ===== src/cgbg_ctrl.sv =====
// Sequencer of the cost grid block: walks loads, merges and query reads.
// Depends on cgbg_pkg for opcodes, step counts and the command struct.
module cgbg_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cgbg_pkg::OP_W-1:0]   i_op,
    output logic                        o_busy,
    output cgbg_pkg::t_ctl_cmd          o_cmd
);
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MEM      = 3'd1;
    localparam logic [2:0] S_MERGE_WR = 3'd2;
    localparam logic [2:0] S_QRUN     = 3'd3;
    localparam logic [2:0] S_QDRAIN   = 3'd4;
    localparam logic [2:0] S_QDONE    = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic [cgbg_pkg::STEP_W-1:0]     r_cnt, n_cnt;
    logic [cgbg_pkg::OP_W-1:0]       r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.step = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_op  = i_op;
                    n_cnt = '0;
                    if (i_op == cgbg_pkg::OP_LOAD || i_op == cgbg_pkg::OP_MERGE) begin
                        n_state = S_MEM;
                    end else if (i_op == cgbg_pkg::OP_QUERY) begin
                        n_state = S_QRUN;
                    end
                end
            end
            S_MEM: begin
                o_cmd.item_port = 1'b1;
                o_cmd.mem_check = 1'b1;
                if (r_op == cgbg_pkg::OP_MERGE) begin
                    n_state = S_MERGE_WR;
                end else begin
                    o_cmd.load_wr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MERGE_WR: begin
                o_cmd.item_port = 1'b1;
                o_cmd.merge_wr  = 1'b1;
                n_state = S_IDLE;
            end
            S_QRUN: begin
                o_cmd.issue = 1'b1;
                if (r_cnt == cgbg_pkg::LAST_STEP) begin
                    n_cnt   = '0;
                    n_state = S_QDRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_QDRAIN: begin
                // let the last reads reach the accumulators
                if (r_cnt == cgbg_pkg::DRAIN_LAST) begin
                    n_state = S_QDONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_QDONE: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_op    <= cgbg_pkg::OP_LOAD;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== src/cgbg_dpath.sv =====
// Datapath of the cost grid block: grid memory, config registers, address
// pipeline and accumulators. Depends on cgbg_pkg; driven by cgbg_ctrl.
module cgbg_dpath #(
    parameter int MAX_WIDTH  = cgbg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cgbg_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = cgbg_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cgbg_pkg::t_ctl_cmd                 i_cmd,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [cgbg_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic [cgbg_pkg::IDX_W-1:0]         i_cell_index,
    input  logic [cgbg_pkg::VAL_W-1:0]         i_cell_value,
    input  logic signed [cgbg_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [cgbg_pkg::COORD_W-1:0] i_query_y,
    output logic                               o_valid,
    output logic [cgbg_pkg::COST_W-1:0]        o_interp_cost,
    output logic signed [cgbg_pkg::GRAD_W-1:0] o_grad_x,
    output logic signed [cgbg_pkg::GRAD_W-1:0] o_grad_y,
    output logic                               o_inside_map
);
    localparam int DIM_W  = cgbg_pkg::DIM_W;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IW     = cgbg_pkg::COORD_W - FRAC_BITS;   // integer part
    localparam int CW     = IW + 2;                          // with offsets
    localparam int LIM_W  = DIM_W + FRAC_BITS + 2;
    localparam int FW     = FRAC_BITS + 1;                   // 1-f weights
    localparam int PW     = 2 * FW;
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int MP_W   = WGT_W + cgbg_pkg::VAL_W;
    localparam int PF     = 2 * FRAC_BITS;
    localparam int SUM_W  = PF + cgbg_pkg::VAL_W;
    localparam int GW     = cgbg_pkg::GRAD_W;

    // Configuration registers
    logic [DIM_W-1:0] r_grid_w, r_grid_h;
    logic [DIM_W-1:0] eff_w, eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= cgbg_pkg::GRID_DIM_RST;
            r_grid_h <= cgbg_pkg::GRID_DIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cgbg_pkg::CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                cgbg_pkg::CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate to the built grid size
    assign eff_w = (32'(r_grid_w) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : r_grid_w;
    assign eff_h = (32'(r_grid_h) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : r_grid_h;

    logic signed [DIM_W:0] w_s, h_s;
    assign w_s = $signed({1'b0, eff_w});
    assign h_s = $signed({1'b0, eff_h});

    // Item capture: load/merge fields and the query setup
    logic [cgbg_pkg::IDX_W-1:0] r_idx;
    logic [cgbg_pkg::VAL_W-1:0] r_val;
    logic signed [IW-1:0]       r_x0, r_y0, r_tx, r_ty;
    logic [FRAC_BITS-1:0]       r_fx, r_fy;
    logic                       r_inside;

    logic signed [IW-1:0]    x0, y0;
    logic [FRAC_BITS-1:0]    fx, fy;
    logic signed [LIM_W-1:0] qx_e, qy_e, lim_x, lim_y, one_l;
    logic                    in_map;

    assign x0 = IW'(i_query_x >>> FRAC_BITS);
    assign y0 = IW'(i_query_y >>> FRAC_BITS);
    assign fx = i_query_x[FRAC_BITS-1:0];
    assign fy = i_query_y[FRAC_BITS-1:0];
    assign qx_e  = LIM_W'(i_query_x);
    assign qy_e  = LIM_W'(i_query_y);
    assign one_l = LIM_W'(1) << FRAC_BITS;
    assign lim_x = LIM_W'(eff_w) << FRAC_BITS;
    assign lim_y = LIM_W'(eff_h) << FRAC_BITS;
    assign in_map = !qx_e[LIM_W-1] && (qx_e + one_l <= lim_x) &&
                    !qy_e[LIM_W-1] && (qy_e + one_l <= lim_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_idx    <= i_cell_index;
            r_val    <= i_cell_value;
            r_x0     <= x0;
            r_y0     <= y0;
            // truncate toward zero: negative with a fraction moves up one
            r_tx     <= (x0 < 0 && fx != '0) ? x0 + IW'(1) : x0;
            r_ty     <= (y0 < 0 && fy != '0) ? y0 + IW'(1) : y0;
            r_fx     <= fx;
            r_fy     <= fy;
            r_inside <= in_map;
        end
    end

    // Stage A: cell coordinate, bounds, address and weight
    cgbg_pkg::t_step         st;
    logic signed [CW-1:0]    cx, cy;
    logic                    on_grid;
    logic [DIM_W-1:0]        cx9, cy9;
    logic [cgbg_pkg::CADDR_W-1:0] caddr;
    logic [FW-1:0]           wx, wy;
    logic [PW-1:0]           wprod;

    assign st = cgbg_pkg::step_info(i_cmd.step);
    assign cx = (st.trunc_base ? CW'(r_tx) : CW'(r_x0)) + CW'(st.dx);
    assign cy = (st.trunc_base ? CW'(r_ty) : CW'(r_y0)) + CW'(st.dy);
    assign on_grid = !cx[CW-1] && !cy[CW-1] && (cx < w_s) && (cy < h_s);
    assign cx9 = DIM_W'(cx);
    assign cy9 = DIM_W'(cy);
    assign caddr = {{DIM_W{1'b0}}, cy9} * {{DIM_W{1'b0}}, eff_w}
                 + {{DIM_W{1'b0}}, cx9};
    assign wx = st.fx_sel ? FW'(r_fx) : (FW'(1) << FRAC_BITS) - FW'(r_fx);
    assign wy = st.fy_sel ? FW'(r_fy) : (FW'(1) << FRAC_BITS) - FW'(r_fy);
    assign wprod = PW'(wx) * PW'(wy);

    logic              r_a_vld, r_a_off;
    logic [ADDR_W-1:0] r_a_addr;
    logic [1:0]        r_a_kind;
    logic              r_a_neg, r_a_dbl;
    logic [WGT_W-1:0]  r_a_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_off  <= !on_grid;
        r_a_addr <= ADDR_W'(caddr);
        r_a_kind <= st.kind;
        r_a_neg  <= st.neg;
        r_a_dbl  <= st.dbl;
        r_a_w    <= WGT_W'(wprod);
    end

    // Grid memory, single port, registered read
    logic [cgbg_pkg::VAL_W-1:0] mem [DEPTH];
    logic [cgbg_pkg::VAL_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]          mem_addr;
    logic                       mem_we;
    logic [cgbg_pkg::CADDR_W-1:0] cell_limit;
    logic                       idx_ok;
    logic                       r_ok;

    assign cell_limit = {{DIM_W{1'b0}}, eff_w} * {{DIM_W{1'b0}}, eff_h};
    assign idx_ok     = cgbg_pkg::CADDR_W'(r_idx) < cell_limit;
    assign mem_addr   = i_cmd.item_port ? ADDR_W'(r_idx) : r_a_addr;
    assign mem_we     = (i_cmd.load_wr && idx_ok) ||
                        (i_cmd.merge_wr && r_ok && (r_val > r_rd_data));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= r_val;
        end
        r_rd_data <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_check) begin
            r_ok <= idx_ok;
        end
    end

    // Stage B: carry step info alongside the memory read
    logic              r_b_vld, r_b_off;
    logic [1:0]        r_b_kind;
    logic              r_b_neg, r_b_dbl;
    logic [WGT_W-1:0]  r_b_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_off  <= r_a_off;
        r_b_kind <= r_a_kind;
        r_b_neg  <= r_a_neg;
        r_b_dbl  <= r_a_dbl;
        r_b_w    <= r_a_w;
    end

    // Stage C: accumulate
    logic [cgbg_pkg::VAL_W-1:0] rd_cell;
    logic [MP_W-1:0]            mprod;
    logic signed [GW-1:0]       mag, term;
    logic [SUM_W-1:0]           r_sum;
    logic signed [GW-1:0]       r_gx, r_gy;

    assign rd_cell = r_b_off ? cgbg_pkg::OFF_CELL : r_rd_data;
    assign mprod   = MP_W'(r_b_w) * MP_W'(rd_cell);
    assign mag     = r_b_dbl ? $signed({2'b00, rd_cell, 1'b0}) : $signed({3'b000, rd_cell});
    assign term    = r_b_neg ? -mag : mag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sum <= '0;
            r_gx  <= '0;
            r_gy  <= '0;
        end else if (r_b_vld) begin
            case (r_b_kind)
                cgbg_pkg::KIND_INTERP: r_sum <= r_sum + SUM_W'(mprod);
                cgbg_pkg::KIND_GX:     r_gx  <= r_gx + term;
                cgbg_pkg::KIND_GY:     r_gy  <= r_gy + term;
                default: ;
            endcase
        end
    end

    // Bring the weighted sum to 16 fraction bits, rounding half up
    logic [cgbg_pkg::COST_W-1:0] cost_q;

    generate
        if (PF > 16) begin : g_round
            logic [SUM_W:0] rnd;
            assign rnd    = ({1'b0, r_sum} + ((SUM_W+1)'(1) << (PF - 17))) >> (PF - 16);
            assign cost_q = cgbg_pkg::COST_W'(rnd);
        end else if (PF == 16) begin : g_exact
            assign cost_q = cgbg_pkg::COST_W'(r_sum);
        end else begin : g_widen
            assign cost_q = cgbg_pkg::COST_W'({r_sum, {(16 - PF){1'b0}}});
        end
    endgenerate

    // Result registers
    logic                         r_valid;
    logic [cgbg_pkg::COST_W-1:0]  r_cost;
    logic signed [GW-1:0]         r_out_gx, r_out_gy;
    logic                         r_out_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_cost   <= r_inside ? cost_q : cgbg_pkg::OFF_COST;
            r_out_gx <= r_gx;
            r_out_gy <= r_gy;
            r_out_in <= r_inside;
        end
    end

    assign o_valid       = r_valid;
    assign o_interp_cost = r_cost;
    assign o_grad_x      = r_out_gx;
    assign o_grad_y      = r_out_gy;
    assign o_inside_map  = r_out_in;

endmodule

// ===== src/cgbg_checker.sv =====
// Port-level checks for the cost grid block, bound to the top level.
// Depends on cgbg_pkg and cost_grid_bilinear_gradient.
module cgbg_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_start,
    input logic [cgbg_pkg::OP_W-1:0]      i_op,
    input logic                           o_busy,
    input logic                           o_valid,
    input logic [cgbg_pkg::COST_W-1:0]    o_interp_cost,
    input logic                           o_inside_map
);
    logic acc;
    assign acc = i_start && !o_busy;

    // a query beat is followed by its result strobe
    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_op == cgbg_pkg::OP_QUERY |-> ##16 o_valid)
        else $error("query result not on time");

    // a result follows a busy cycle and is never back to back
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy) && !o_busy)
        else $error("result strobe outside a query");

    // an unknown opcode is dropped without going busy
    a_unknown_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_op != cgbg_pkg::OP_LOAD && i_op != cgbg_pkg::OP_MERGE &&
        i_op != cgbg_pkg::OP_QUERY |=> !o_busy)
        else $error("unknown op started work");

    // off-map results carry the fixed off-grid cost
    a_off_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_inside_map |-> o_interp_cost == cgbg_pkg::OFF_COST)
        else $error("off-map cost wrong");

endmodule

bind cost_grid_bilinear_gradient cgbg_checker u_cgbg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .i_op          (i_op),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_interp_cost (o_interp_cost),
    .o_inside_map  (o_inside_map)
);
